// ----- hw/rtl/grgc_pkg.sv -----
// ----------------------------------------------------------------------------
// grgc_pkg: shared constants and types of the route group colorer
// Widths, sizes, status codes and the mask memory write word.
// ----------------------------------------------------------------------------
`default_nettype none

package grgc_pkg;

  localparam int NUM_LOCATIONS = 4096;
  localparam int LOC_W         = $clog2(NUM_LOCATIONS);
  localparam int MAX_GROUPS    = 64;
  localparam int GROUP_W       = $clog2(MAX_GROUPS);
  localparam int MAX_STOPS     = 256;
  localparam int STOP_IDX_W    = $clog2(MAX_STOPS);
  localparam int STOP_CNT_W    = STOP_IDX_W + 1;
  localparam int ROUTE_W       = 16;
  localparam int COUNT_W       = 17;
  localparam int STATUS_W      = 2;

  localparam logic [COUNT_W-1:0]  COUNT_MAX       = {COUNT_W{1'b1}};

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_GROUP = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic               clear;
    logic               set;
    logic [LOC_W-1:0]   addr;
    logic [GROUP_W-1:0] bit_sel;
  } mask_wr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/grgc_mask_ram.sv -----
// ----------------------------------------------------------------------------
// grgc_mask_ram: per-location group mask memory
// One read port with registered data; one write port that either clears a
// whole word or sets a single group bit.
// ----------------------------------------------------------------------------
`default_nettype none

module grgc_mask_ram (
  input  wire logic                              clk,
  input  wire grgc_pkg::mask_wr_t                wr,
  input  wire logic                              rd_en,
  input  wire logic [grgc_pkg::LOC_W-1:0]        rd_addr,
  output logic      [grgc_pkg::MAX_GROUPS-1:0]   rd_data
);

  logic [grgc_pkg::MAX_GROUPS-1:0] mem [grgc_pkg::NUM_LOCATIONS];

  always_ff @(posedge clk) begin
    if (wr.clear) begin
      mem[wr.addr] <= '0;
    end else if (wr.set) begin
      mem[wr.addr][wr.bit_sel] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/grgc_stop_buf.sv -----
// ----------------------------------------------------------------------------
// grgc_stop_buf: stop buffer of the current route
// Holds the locations of the route's stops for the marking walk.
// ----------------------------------------------------------------------------
`default_nettype none

module grgc_stop_buf (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [grgc_pkg::STOP_IDX_W-1:0]   waddr,
  input  wire logic [grgc_pkg::LOC_W-1:0]        wdata,
  input  wire logic [grgc_pkg::STOP_IDX_W-1:0]   raddr,
  output logic      [grgc_pkg::LOC_W-1:0]        rdata
);

  logic [grgc_pkg::LOC_W-1:0] mem [grgc_pkg::MAX_STOPS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/grgc_group_count.sv -----
// ----------------------------------------------------------------------------
// grgc_group_count: member counters of the conflict groups
// Saturating counters in a small memory with registered read, cleared by the
// clearing pass after reset, one incremented per assigned route.
// ----------------------------------------------------------------------------
`default_nettype none

module grgc_group_count (
  input  wire logic                             clk,
  input  wire logic                             clr,
  input  wire logic [grgc_pkg::GROUP_W-1:0]     clr_sel,
  input  wire logic                             inc,
  input  wire logic [grgc_pkg::GROUP_W-1:0]     sel,
  output logic      [grgc_pkg::COUNT_W-1:0]     size_next
);

  logic [grgc_pkg::COUNT_W-1:0] counts [grgc_pkg::MAX_GROUPS];
  logic [grgc_pkg::COUNT_W-1:0] cur;

  assign size_next = (cur == grgc_pkg::COUNT_MAX) ? cur : cur + 1'b1;

  always_ff @(posedge clk) begin
    if (clr) begin
      counts[clr_sel] <= '0;
    end else if (inc) begin
      counts[sel] <= size_next;
    end
    cur <= counts[sel];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/greedy_route_group_colorer_top.sv -----
// ----------------------------------------------------------------------------
// greedy_route_group_colorer_top: first-fit group assignment of routes
// Routes stream in as stop words; each finished route gets the lowest group
// not used by an earlier route sharing one of its locations, if any group is free.
// ----------------------------------------------------------------------------
// usage
//   input channel: one word per stop (location, last_stop), valid/ready
//   output channel: one word per finished route (route_index, group,
//   group_size, status), valid/ready, held in an output register
//   after reset the mask memory and the group counts are cleared one
//   location per cycle, with in_ready low until the clearing pass is done
//   a stop that is not the last one is taken every cycle (one mask read)
//   after the last stop the mask is folded (ST_FOLD), the lowest free group
//   is picked (ST_PICK), the group bit is set at each buffered stop, up to
//   256 (ST_WALK, skipped when no group is free), and the count is updated
//   and the result loaded (ST_COUNT) once the output register is free
//   the next route is taken while a result waits; a second result waits in
//   the count step until the receiver takes the first
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_route_group_colorer_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [grgc_pkg::LOC_W-1:0]         location,
  input  wire logic                               last_stop,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      [grgc_pkg::ROUTE_W-1:0]       route_index,
  output logic      [grgc_pkg::GROUP_W-1:0]       group,
  output logic      [grgc_pkg::COUNT_W-1:0]       group_size,
  output logic      [grgc_pkg::STATUS_W-1:0]      status
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_FOLD  = 3'd2;
  localparam logic [2:0] ST_PICK  = 3'd3;
  localparam logic [2:0] ST_WALK  = 3'd4;
  localparam logic [2:0] ST_COUNT = 3'd5;

  logic [2:0]                          state;
  logic [grgc_pkg::LOC_W-1:0]          clr_addr;
  logic [grgc_pkg::STOP_CNT_W-1:0]     stops;
  logic [grgc_pkg::STOP_CNT_W-1:0]     walk_idx;
  logic                                overflowed;
  logic                                no_free;
  logic [grgc_pkg::MAX_GROUPS-1:0]     conflict;
  logic [grgc_pkg::GROUP_W-1:0]        group_sel;
  logic [grgc_pkg::ROUTE_W-1:0]        route_cnt;
  logic                                rd_pend;
  logic                                wr_pend;

  logic                                in_fire;
  logic                                walk_rd;
  logic                                out_free;
  logic                                out_load;
  logic                                count_inc;
  logic [grgc_pkg::MAX_GROUPS-1:0]     free_groups;
  logic [grgc_pkg::MAX_GROUPS-1:0]     mask_q;
  logic [grgc_pkg::LOC_W-1:0]          buf_q;
  logic [grgc_pkg::COUNT_W-1:0]        size_next;
  grgc_pkg::mask_wr_t                  mask_wr;

  function automatic logic [grgc_pkg::GROUP_W-1:0] lowest_set(
    input logic [grgc_pkg::MAX_GROUPS-1:0] f
  );
    logic [grgc_pkg::MAX_GROUPS-1:0] one;
    logic [grgc_pkg::GROUP_W-1:0]    idx;
    one = f & (~f + {{(grgc_pkg::MAX_GROUPS-1){1'b0}}, 1'b1});
    idx = '0;
    for (int i = 0; i < grgc_pkg::MAX_GROUPS; i++) begin
      if (one[i]) begin
        idx = idx | grgc_pkg::GROUP_W'(i);
      end
    end
    return idx;
  endfunction

  assign in_ready    = (state == ST_RUN);
  assign in_fire     = in_valid && in_ready;
  assign walk_rd     = (state == ST_WALK) && (walk_idx != stops);
  assign out_free    = !out_valid || out_ready;
  assign out_load    = (state == ST_COUNT) && out_free;
  assign count_inc   = out_load && !no_free;
  assign free_groups = ~conflict;

  assign mask_wr.clear   = (state == ST_CLEAR);
  assign mask_wr.set     = wr_pend;
  assign mask_wr.addr    = (state == ST_CLEAR) ? clr_addr : buf_q;
  assign mask_wr.bit_sel = group_sel;

  grgc_mask_ram u_mask_ram (
    .clk     (clk),
    .wr      (mask_wr),
    .rd_en   (in_fire),
    .rd_addr (location),
    .rd_data (mask_q)
  );

  grgc_stop_buf u_stop_buf (
    .clk   (clk),
    .we    (in_fire && !stops[grgc_pkg::STOP_CNT_W-1]),
    .waddr (stops[grgc_pkg::STOP_IDX_W-1:0]),
    .wdata (location),
    .raddr (walk_idx[grgc_pkg::STOP_IDX_W-1:0]),
    .rdata (buf_q)
  );

  grgc_group_count u_group_count (
    .clk       (clk),
    .clr       (state == ST_CLEAR),
    .clr_sel   (clr_addr[grgc_pkg::GROUP_W-1:0]),
    .inc       (count_inc),
    .sel       (group_sel),
    .size_next (size_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      stops      <= '0;
      walk_idx   <= '0;
      overflowed <= 1'b0;
      no_free    <= 1'b0;
      conflict   <= '0;
      route_cnt  <= '0;
      rd_pend    <= 1'b0;
      wr_pend    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_pend <= in_fire;
      wr_pend <= walk_rd;
      if (rd_pend) begin
        conflict <= conflict | mask_q;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == grgc_pkg::LOC_W'(grgc_pkg::NUM_LOCATIONS - 1)) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (in_fire) begin
            if (!stops[grgc_pkg::STOP_CNT_W-1]) begin
              stops <= stops + 1'b1;
            end else begin
              overflowed <= 1'b1;
            end
            if (last_stop) begin
              state <= ST_FOLD;
            end
          end
        end
        ST_FOLD: begin
          state <= ST_PICK;
        end
        ST_PICK: begin
          walk_idx <= '0;
          if (free_groups == '0) begin
            no_free <= 1'b1;
            state   <= ST_COUNT;
          end else begin
            no_free   <= 1'b0;
            group_sel <= lowest_set(free_groups);
            state     <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_rd) begin
            walk_idx <= walk_idx + 1'b1;
          end else begin
            state <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          if (out_free) begin
            route_index <= route_cnt;
            group       <= no_free ? '0 : group_sel;
            group_size  <= no_free ? '0 : size_next;
            status      <= no_free ? grgc_pkg::STATUS_NO_GROUP :
                           (overflowed ? grgc_pkg::STATUS_OVERFLOW : grgc_pkg::STATUS_OK);
            route_cnt   <= route_cnt + 1'b1;
            stops       <= '0;
            overflowed  <= 1'b0;
            conflict    <= '0;
            state       <= ST_RUN;
          end
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_no_group_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == grgc_pkg::STATUS_NO_GROUP) |-> (group == '0) && (group_size == '0))
    else $error("unassigned route carries a group or size");

  a_assigned_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != grgc_pkg::STATUS_NO_GROUP) |-> (group_size != '0))
    else $error("assigned route reports empty group");

  a_result_from_count: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_COUNT)
    else $error("result loaded outside the count step");

  a_mark_in_walk: assert property (@(posedge clk) disable iff (rst)
    wr_pend |-> (state == ST_WALK) || (state == ST_COUNT))
    else $error("mask bit set outside the marking walk");
`endif

endmodule

`default_nettype wire
